// File: rtl/paragraph_aware_text_chunker_macros.svh
// ----------------------------------------------------------------------------
// Paragraph-aware text chunker: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PARAGRAPH_AWARE_TEXT_CHUNKER_MACROS_SVH
`define PARAGRAPH_AWARE_TEXT_CHUNKER_MACROS_SVH

// Same-cycle implication
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// Paragraph-aware text chunker: package
// Field widths, character codes and the queued result record.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned START_W = 32;
  localparam int unsigned LEN_W   = 25;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [BYTE_W-1:0]  NEWLINE     = 8'h0A;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd4096;

  // Result queue depth and pointer widths
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               final_chunk;
    logic               last_of_run;
    logic               overflow;
  } chunk_res_t;

endpackage

// File: rtl/paragraph_aware_text_chunker.sv
// ----------------------------------------------------------------------------
// Paragraph-aware text chunker
// Splits a byte stream into chunks near a size limit, preferring paragraph
// breaks, then line breaks, then a hard cut.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------
//  in_     | in  | in_tvalid / in_tready   | tdata text_byte, tlast end_of_text
//  out_    | out | out_tvalid / out_tready | tdata start+length, tuser flags,
//          |     |                         | tlast last_of_run
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data chunk_limit
//
// One byte is taken per cycle; its zero, one or two chunk records are
// computed in the same cycle and land in a four-entry result queue.
// The queue drains one record per cycle while out_tready is high; a byte that
// yields two records takes two transfers. Input stalls only when fewer than two
// slots are free. Synchronous active-low reset clears the text state, the queue
// and sets the limit to 4096. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "paragraph_aware_text_chunker_macros.svh"

module paragraph_aware_text_chunker
  import ptc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data,     // chunk_limit
  // text bytes
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // [7:0] text_byte
  input  logic                  in_tlast,     // end_of_text
  // chunk records
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,    // [31:0] chunk_start, [56:32] chunk_length
  output logic [1:0]            out_tuser,    // [0] final_chunk, [1] position_overflow
  output logic                  out_tlast     // last_of_run
);

  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned CW = (PW > LEN_W) ? PW : LEN_W;

  // Text state
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      start_r, start_nxt;
  logic [PW-1:0]      nl_r, nl_nxt;
  logic               nl_valid_r, nl_valid_nxt;
  logic [PW-1:0]      pair_r, pair_nxt;
  logic               pair_valid_r, pair_valid_nxt;
  logic               prev_nl_r, prev_nl_nxt;
  logic               ovf_r, ovf_nxt;
  logic [LIMIT_W-1:0] lim_r;

  // Result queue
  chunk_res_t         q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  // Step logic
  logic               in_fire, out_fire;
  logic               is_nl, eot;
  logic [LIMIT_W-1:0] lim_eff;
  logic [PW-1:0]      pos_off, pos_inc;
  logic               pair_hit, pair_vld, pair_ok, nl_vld, nl_ok;
  logic [PW-1:0]      pair_pos, nl_pos, pair_off, nl_off;
  logic               at_lim, at_lim1, cut_made, rest;
  logic [PW-1:0]      cut, cut_len, fin_base, fin_len;
  chunk_res_t         res0, res1;
  logic [1:0]         n_push;
  logic               text_idle;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;
  assign in_tready = (cnt_r <= QCNT_W'(QDEPTH - 2));

  // Text state back at its start-of-text values
  assign text_idle = (pos_r == '0) && (start_r == '0) && !nl_valid_r && !pair_valid_r;

  // Evaluate one byte against the open chunk
  always_comb begin
    is_nl    = (in_tdata == NEWLINE);
    eot      = in_tlast;
    lim_eff  = (lim_r == '0) ? LIMIT_W'(1) : lim_r;
    pos_off  = pos_r - start_r;
    pos_inc  = pos_r + PW'(1);

    nl_pos   = is_nl ? pos_r : nl_r;
    nl_vld   = is_nl | nl_valid_r;
    pair_hit = is_nl & prev_nl_r;
    pair_pos = pair_hit ? (pos_r - PW'(1)) : pair_r;
    pair_vld = pair_hit | pair_valid_r;

    pair_off = pair_pos - start_r;
    nl_off   = nl_pos - start_r;
    pair_ok  = pair_vld && (pair_off != '0) && (pair_off <= pos_off);
    nl_ok    = nl_vld && (nl_off != '0) && (nl_off <= pos_off);

    at_lim1  = (CW'(pos_off) == (CW'(lim_eff) + CW'(1)));
    at_lim   = (CW'(pos_off) == CW'(lim_eff));
    cut_made = at_lim1 | (at_lim & (~is_nl | eot));

    // Pick the cut: paragraph, then line (not after waiting), then hard
    if (pair_ok) begin
      cut = pair_pos + PW'(1);
    end else if (!at_lim1 && nl_ok) begin
      cut = nl_pos + PW'(1);
    end else begin
      cut = pos_r;
    end

    rest     = ~cut_made | (cut != pos_inc);
    cut_len  = cut - start_r;
    fin_base = cut_made ? cut : start_r;
    fin_len  = pos_inc - fin_base;

    ovf_nxt  = ovf_r | ((pos_r == '1) & ~eot);

    res1.start       = 32'(fin_base);
    res1.length      = LEN_W'(fin_len);
    res1.final_chunk = 1'b1;
    res1.last_of_run = 1'b1;
    res1.overflow    = ovf_nxt;

    if (cut_made) begin
      res0.start       = 32'(start_r);
      res0.length      = LEN_W'(cut_len);
      res0.final_chunk = eot & ~rest;
      res0.last_of_run = ~(eot & rest);
      res0.overflow    = ovf_nxt;
    end else begin
      res0 = res1;
    end

    n_push = {1'b0, cut_made} + {1'b0, eot & rest};

    // Advance or clear the text state
    if (eot) begin
      pos_nxt        = '0;
      start_nxt      = '0;
      nl_nxt         = '0;
      nl_valid_nxt   = 1'b0;
      pair_nxt       = '0;
      pair_valid_nxt = 1'b0;
      prev_nl_nxt    = 1'b0;
    end else begin
      pos_nxt        = pos_inc;
      start_nxt      = cut_made ? cut : start_r;
      nl_nxt         = nl_pos;
      nl_valid_nxt   = nl_vld;
      pair_nxt       = pair_pos;
      pair_valid_nxt = pair_vld;
      prev_nl_nxt    = is_nl;
    end
  end

  // Hold text state and limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      start_r      <= '0;
      nl_r         <= '0;
      nl_valid_r   <= 1'b0;
      pair_r       <= '0;
      pair_valid_r <= 1'b0;
      prev_nl_r    <= 1'b0;
      ovf_r        <= 1'b0;
      lim_r        <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lim_r <= cfg_data;
      end
      if (in_fire) begin
        pos_r        <= pos_nxt;
        start_r      <= start_nxt;
        nl_r         <= nl_nxt;
        nl_valid_r   <= nl_valid_nxt;
        pair_r       <= pair_nxt;
        pair_valid_r <= pair_valid_nxt;
        prev_nl_r    <= prev_nl_nxt;
        ovf_r        <= ovf_nxt;
      end
    end
  end

  // Queue control: push up to two records, drop one per output transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (in_fire ? QCNT_W'(n_push) : '0) - QCNT_W'(out_fire);
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (in_fire && (n_push != 2'd0)) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_fire && (n_push == 2'd2)) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  // Present the queue head
  always_comb begin
    out_tvalid = (cnt_r != '0);
    out_tdata  = {7'b0, q_r[rd_ptr_r].length, q_r[rd_ptr_r].start};
    out_tuser  = {q_r[rd_ptr_r].overflow, q_r[rd_ptr_r].final_chunk};
    out_tlast  = q_r[rd_ptr_r].last_of_run;
  end

  `PTC_ASSERT_NOW(a_q_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH), "result queue overrun")
  `PTC_ASSERT_NEXT(a_eot_clear, in_fire && in_tlast, text_idle, "text state not cleared")
  `PTC_ASSERT_NEXT(a_run_tail, out_fire && !out_tlast, out_tvalid, "second record of a byte missing")
  `PTC_ASSERT_NEXT(a_ovf_sticky, ovf_r, ovf_r, "overflow flag dropped")

endmodule

// File: test/paragraph_aware_text_chunker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paragraph-aware text chunker: testbench
// Streams texts through the chunker under a range of chunk limits, from the
// zero and one extremes up to the 24-bit maximum. Each accepted byte updates
// a local copy of the chunker state. That copy yields the chunk records the
// block must produce, and each record that comes out is checked field by
// field. Both stream sides idle and stall in random bursts; the last phase
// runs with no idling.
// ----------------------------------------------------------------------------
module paragraph_aware_text_chunker_test
  import ptc_pkg::*;
();

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned NUM_PHASES    = 13;

  // --------------------------------------------------------------------------
  // Chunk boundary scoreboard: tracks the text state and the pending records
  // --------------------------------------------------------------------------
  class chunk_boundary_scoreboard;
    logic [LIMIT_W-1:0] chunk_limit;
    logic [START_W-1:0] next_pos;
    logic [START_W-1:0] open_start;
    logic [START_W-1:0] last_nl_pos;
    logic [START_W-1:0] last_pair_pos;
    bit                 nl_seen;
    bit                 pair_seen;
    bit                 prev_nl;
    bit                 overflow_seen;
    chunk_res_t         expected_chunks[$];
    int unsigned        failures;

    function new();
      chunk_limit   = LIMIT_RESET;
      overflow_seen = 1'b0;
      failures      = 0;
      clear_text();
    endfunction

    function void clear_text();
      next_pos      = '0;
      open_start    = '0;
      last_nl_pos   = '0;
      last_pair_pos = '0;
      nl_seen       = 1'b0;
      pair_seen     = 1'b0;
      prev_nl       = 1'b0;
    endfunction

    // True when mark lies in (open_start, open_start + span]
    function bit in_window(bit valid, logic [START_W-1:0] mark, logic [START_W-1:0] span);
      logic [START_W-1:0] off;
      off = mark - open_start;
      return valid && (off != '0) && (off <= span);
    endfunction

    // Advance the text state by one accepted byte and queue its records
    function void note_text_byte(logic [BYTE_W-1:0] text_byte, logic eot);
      logic [START_W-1:0] pos;
      logic [START_W-1:0] span;
      logic [START_W-1:0] lim;
      logic [START_W-1:0] cut;
      logic [START_W-1:0] len;
      bit                 is_nl;
      bit                 cut_made;
      bit                 rest;
      chunk_res_t         rec [2];
      int                 n;
      int                 i;
      pos      = next_pos;
      is_nl    = (text_byte == NEWLINE);
      lim      = (chunk_limit == '0) ? 32'd1 : START_W'(chunk_limit);
      span     = pos - open_start;
      cut_made = 1'b0;
      rest     = 1'b1;
      cut      = '0;
      n        = 0;

      if (pos == {START_W{1'b1}} && !eot)
        overflow_seen = 1'b1;

      // track the latest newline and the latest newline pair
      if (is_nl) begin
        if (prev_nl) begin
          last_pair_pos = pos - 1;
          pair_seen     = 1'b1;
        end
        last_nl_pos = pos;
        nl_seen     = 1'b1;
      end
      prev_nl = is_nl;

      // pick the cut: paragraph break, then line break (not one byte past the limit), then hard cut
      if (span == lim + 1) begin
        cut      = in_window(pair_seen, last_pair_pos, span) ? last_pair_pos + 1 : pos;
        cut_made = 1'b1;
      end else if (span == lim && (!is_nl || eot)) begin
        if (in_window(pair_seen, last_pair_pos, span))
          cut = last_pair_pos + 1;
        else if (in_window(nl_seen, last_nl_pos, span))
          cut = last_nl_pos + 1;
        else
          cut = pos;
        cut_made = 1'b1;
      end

      if (cut_made) begin
        rest = (cut != pos + 1);
        len  = cut - open_start;
        rec[n] = '{start: open_start, length: len[LEN_W-1:0], final_chunk: eot && !rest,
                   last_of_run: 1'b0, overflow: overflow_seen};
        n++;
        open_start = cut;
      end

      // close the text with whatever bytes remain
      if (eot) begin
        if (rest) begin
          len = pos - open_start + 1;
          rec[n] = '{start: open_start, length: len[LEN_W-1:0], final_chunk: 1'b1,
                     last_of_run: 1'b0, overflow: overflow_seen};
          n++;
        end
        clear_text();
      end else begin
        next_pos = pos + 1;
      end

      if (n > 0)
        rec[n-1].last_of_run = 1'b1;
      for (i = 0; i < n; i++)
        expected_chunks = {expected_chunks, rec[i]};
    endfunction

    function void compare_field(string name, logic [START_W-1:0] want, logic [START_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted record against the oldest expectation
    function void check_chunk(chunk_res_t got);
      chunk_res_t want;
      if (expected_chunks.size() == 0) begin
        $display("%0t: unexpected chunk record, expected none, actual start %0d length %0d",
                 $time, got.start, got.length);
        failures++;
        return;
      end
      want = expected_chunks.pop_front();
      compare_field("chunk_start", want.start, got.start);
      compare_field("chunk_length", START_W'(want.length), START_W'(got.length));
      compare_field("final_chunk", START_W'(want.final_chunk), START_W'(got.final_chunk));
      compare_field("last_of_run", START_W'(want.last_of_run), START_W'(got.last_of_run));
      compare_field("position_overflow", START_W'(want.overflow), START_W'(got.overflow));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [63:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tlast;

  bit                       tail_phase;
  bit                       calm_text;
  chunk_boundary_scoreboard sb;

  paragraph_aware_text_chunker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one byte, sometimes with a random idle burst ahead of it
  task automatic send_byte(input logic [7:0] text_byte, input logic eot);
    int unsigned gap;
    if (!tail_phase && !calm_text && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= text_byte;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    sb.note_text_byte(text_byte, eot);
  endtask

  // Send a whole text, end of text on its last character
  task automatic send_text(input string s);
    int i;
    calm_text = 1'b0;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
  endtask

  // Random text sized around the limit up to 64 and short above it, newline density per text
  task automatic send_random_text(input int unsigned limit_val, output int unsigned len);
    int unsigned nl_pct;
    int unsigned k;
    logic [7:0]  b;
    case ($urandom_range(0, 4))
      0:       nl_pct = 0;
      1:       nl_pct = 8;
      2:       nl_pct = 25;
      3:       nl_pct = 50;
      default: nl_pct = 90;
    endcase
    calm_text = ($urandom_range(0, 3) == 0);
    len = (limit_val <= 64) ? $urandom_range(1, 3 * limit_val + 8) : $urandom_range(1, 48);
    for (k = 0; k < len; k++) begin
      b = ($urandom_range(0, 99) < nl_pct) ? NEWLINE : 8'($urandom_range(0, 255));
      send_byte(b, k == len - 1);
    end
  endtask

  // Write the limit once the block has drained
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.chunk_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side back-pressure: ready runs, then stall bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 40)) @(negedge clk);
      if (!tail_phase) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end
    end
  end

  // Check every record transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_chunk('{start: out_tdata[31:0], length: out_tdata[56:32],
                       final_chunk: out_tuser[0], last_of_run: out_tlast,
                       overflow: out_tuser[1]});
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [LIMIT_W-1:0] phase_limit [NUM_PHASES];
    int unsigned        phase_budget;
    int unsigned        phase_items;
    int unsigned        text_len;
    int unsigned        p;
    sb         = new();
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    tail_phase = 1'b0;
    calm_text  = 1'b0;
    phase_limit = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd8, 24'd11,
                    24'd16, 24'hFFFFFF, 24'd24, 24'd3};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limit: single-byte text and a text of extreme byte values
    send_text("\n");
    calm_text = 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Limit 4: paragraph cut, hard cut with the tail on the same byte,
    // newline at the limit followed by more text, newline at the limit ending it
    write_limit(24'd4);
    send_text("a\n\nbcd");
    send_text("abcde");
    send_text("abcd\ne");
    send_text("abcd\n");

    // Random texts across the limit settings
    for (p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      tail_phase   = (p == NUM_PHASES - 1);
      phase_budget = (phase_limit[p] > 64) ? 40 : 72;
      phase_items  = 0;
      while (phase_items < phase_budget) begin
        send_random_text(phase_limit[p], text_len);
        phase_items += text_len;
      end
    end

    // Drain and report
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_chunks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
